// File: design/tcc_pkg.sv
// shared widths, latencies and types of the triangle circumcenter unit
package tcc_pkg;

   // coordinate format of the stream fields
   localparam int COORD_W = 32;

   // chunk size of the pipelined multipliers
   localparam int CHUNK_W = 32;
   // register stages through one multiplier
   localparam int MUL_LAT = 4;

   // internal word sizes
   localparam int DIFF_W = COORD_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int NORM_W = PROD_W + 1;
   localparam int SQ_W   = PROD_W + 1;
   localparam int A_W    = SQ_W + DIFF_W + 1;
   localparam int CR_W   = A_W + NORM_W + 1;
   localparam int DEN_W  = 2 * NORM_W + 1;
   localparam int QUO_W  = COORD_W + 1;
   localparam int REM_W  = ((CR_W > DEN_W + QUO_W) ? CR_W : DEN_W + QUO_W) + 1;

   // bit positions in the result tuser
   localparam int USER_DEGENERATE = 0;
   localparam int USER_SATURATED  = 1;

endpackage

// File: design/triangle_circumcenter_3d_unit.sv
// circumcenter of a 3d triangle, fully pipelined
// throughput: one triangle per cycle; the pipeline advances whenever the
//   output register is empty or being taken
// reset: synchronous, clears every valid bit and sets the threshold to 1
module triangle_circumcenter_3d_unit
   import tcc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [31:0]            csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z
   input  logic [9*COORD_W-1:0]   req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // center_x, center_y, center_z
   output logic [3*COORD_W-1:0]   rsp_tdata,
   // degenerate, saturated
   output logic [1:0]             rsp_tuser
);

   localparam int ML         = MUL_LAT;
   localparam int PASS_STAGE = ML + 2;
   localparam int TOT        = 3 * ML + 5 + QUO_W;
   localparam int DIV0       = 3 * ML + 5;
   localparam int OUT_W      = QUO_W + 3;
   localparam logic signed [OUT_W-1:0] SAT_MAX = {{5{1'b0}}, {(COORD_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] SAT_MIN = {{5{1'b1}}, {(COORD_W-1){1'b0}}};

   typedef struct packed {
      logic                     pass;
      logic [2:0][COORD_W-1:0]  p;
      logic [2:0][COORD_W-1:0]  mid;
   } side_type;

   logic                      en;
   logic [31:0]               thr_ff;
   logic                      valid_ff [TOT];
   side_type                  side_ff  [TOT];
   logic signed [COORD_W-1:0] c [9];
   logic [COORD_W-1:0]        mid_c [3];

   logic signed [DIFF_W-1:0]  v_ff [3];
   logic signed [DIFF_W-1:0]  w_ff [3];
   logic signed [DIFF_W-1:0]  vd_ff [ML+1][3];
   logic signed [DIFF_W-1:0]  wd_ff [ML+1][3];
   logic signed [PROD_W-1:0]  xa [3];
   logic signed [PROD_W-1:0]  xb [3];
   logic signed [PROD_W-1:0]  vsq [3];
   logic signed [PROD_W-1:0]  wsq [3];
   logic signed [NORM_W-1:0]  n_ff [3];
   logic signed [NORM_W-1:0]  nd_ff [ML+1][3];
   logic signed [SQ_W-1:0]    vv_ff;
   logic signed [SQ_W-1:0]    ww_ff;
   logic [NORM_W-1:0]         nabs [3];
   logic                      pass_c;
   logic signed [SQ_W+DIFF_W-1:0] t1 [3];
   logic signed [SQ_W+DIFF_W-1:0] t2 [3];
   logic signed [2*NORM_W-1:0]    nsq [3];
   logic signed [A_W-1:0]     a_ff [3];
   logic [DEN_W-1:0]          den_ff;
   logic [DEN_W-1:0]          nn_c;
   logic [DEN_W-1:0]          dd_ff [ML+1];
   logic signed [A_W+NORM_W-1:0] ca [3];
   logic signed [A_W+NORM_W-1:0] cb [3];
   logic signed [CR_W-1:0]    cr_ff [3];
   logic [CR_W-1:0]           cr_abs [3];
   logic [REM_W-1:0]          mag_ff [3];
   logic                      neg_ff [3];
   logic                      ovf_ff [3];
   logic [DEN_W-1:0]          den_h_ff;

   logic [REM_W-1:0]          rem_ff [QUO_W][3];
   logic [QUO_W-1:0]          quo_ff [QUO_W][3];
   logic                      dneg_ff [QUO_W][3];
   logic                      dovf_ff [QUO_W][3];
   logic [DEN_W-1:0]          dden_ff [QUO_W];
   logic [REM_W-1:0]          rsrc [QUO_W][3];
   logic [QUO_W-1:0]          qsrc [QUO_W][3];
   logic [DEN_W-1:0]          dsrc [QUO_W];
   logic [REM_W:0]            trial [QUO_W][3];

   logic [3*COORD_W-1:0]      rsp_data_ff, rsp_data_in;
   logic [1:0]                rsp_user_ff, rsp_user_in;
   logic                      rsp_valid_ff;

   // pipeline moves when the output register can take a new result
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 32'd1;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   // unpack vertices and first edge midpoint
   always_comb begin
      logic signed [COORD_W:0] ms;
      for (int k = 0; k < 9; k++) begin
         c[k] = $signed(req_tdata[k*COORD_W +: COORD_W]);
      end
      for (int k = 0; k < 3; k++) begin
         ms       = DIFF_W'(c[k]) + DIFF_W'(c[3+k]);
         mid_c[k] = ms[COORD_W:1];
      end
   end

   // valid bits along the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= req_tvalid;
         for (int i = 1; i < TOT; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // side payload along the pipeline, plane test joins after the normal
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0].pass <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            side_ff[0].p[k]   <= c[k];
            side_ff[0].mid[k] <= mid_c[k];
         end
         for (int i = 1; i < TOT; i++) begin
            if (i == PASS_STAGE) begin
               side_ff[i] <= {pass_c, side_ff[i-1].p, side_ff[i-1].mid};
            end else begin
               side_ff[i] <= side_ff[i-1];
            end
         end
      end
   end

   // edge vectors
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            v_ff[k] <= DIFF_W'(c[3+k]) - DIFF_W'(c[k]);
            w_ff[k] <= DIFF_W'(c[6+k]) - DIFF_W'(c[k]);
         end
      end
   end

   // products of edge components
   for (genvar k = 0; k < 3; k++) begin : g_edge_mul
      localparam int K1 = (k + 1) % 3;
      localparam int K2 = (k + 2) % 3;
      tcc_mul #(.A_WIDTH(DIFF_W), .B_WIDTH(DIFF_W)) u_xa (
         .clock(clock), .en(en), .a(v_ff[K1]), .b(w_ff[K2]), .p(xa[k]));
      tcc_mul #(.A_WIDTH(DIFF_W), .B_WIDTH(DIFF_W)) u_xb (
         .clock(clock), .en(en), .a(v_ff[K2]), .b(w_ff[K1]), .p(xb[k]));
      tcc_mul #(.A_WIDTH(DIFF_W), .B_WIDTH(DIFF_W)) u_vsq (
         .clock(clock), .en(en), .a(v_ff[k]), .b(v_ff[k]), .p(vsq[k]));
      tcc_mul #(.A_WIDTH(DIFF_W), .B_WIDTH(DIFF_W)) u_wsq (
         .clock(clock), .en(en), .a(w_ff[k]), .b(w_ff[k]), .p(wsq[k]));
   end

   // normal and squared edge lengths
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            n_ff[k] <= NORM_W'(xa[k]) - NORM_W'(xb[k]);
         end
         vv_ff <= SQ_W'(vsq[0]) + SQ_W'(vsq[1]) + SQ_W'(vsq[2]);
         ww_ff <= SQ_W'(wsq[0]) + SQ_W'(wsq[1]) + SQ_W'(wsq[2]);
      end
   end

   // coordinate plane test against the threshold
   always_comb begin
      pass_c = 1'b0;
      for (int k = 0; k < 3; k++) begin
         nabs[k] = n_ff[k][NORM_W-1] ? NORM_W'(-n_ff[k]) : NORM_W'(n_ff[k]);
         if (nabs[k] > NORM_W'(thr_ff)) begin
            pass_c = 1'b1;
         end
      end
   end

   // delay lines for operands used again later
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            vd_ff[0][k] <= v_ff[k];
            wd_ff[0][k] <= w_ff[k];
            nd_ff[0][k] <= n_ff[k];
            for (int i = 1; i <= ML; i++) begin
               vd_ff[i][k] <= vd_ff[i-1][k];
               wd_ff[i][k] <= wd_ff[i-1][k];
               nd_ff[i][k] <= nd_ff[i-1][k];
            end
         end
         dd_ff[0] <= den_ff;
         for (int i = 1; i <= ML; i++) begin
            dd_ff[i] <= dd_ff[i-1];
         end
      end
   end

   // weighted edges and normal squares
   for (genvar k = 0; k < 3; k++) begin : g_weight_mul
      tcc_mul #(.A_WIDTH(SQ_W), .B_WIDTH(DIFF_W)) u_t1 (
         .clock(clock), .en(en), .a(vv_ff), .b(wd_ff[ML][k]), .p(t1[k]));
      tcc_mul #(.A_WIDTH(SQ_W), .B_WIDTH(DIFF_W)) u_t2 (
         .clock(clock), .en(en), .a(ww_ff), .b(vd_ff[ML][k]), .p(t2[k]));
      tcc_mul #(.A_WIDTH(NORM_W), .B_WIDTH(NORM_W)) u_nsq (
         .clock(clock), .en(en), .a(n_ff[k]), .b(n_ff[k]), .p(nsq[k]));
   end

   always_comb begin
      nn_c = DEN_W'($unsigned(nsq[0])) + DEN_W'($unsigned(nsq[1]))
           + DEN_W'($unsigned(nsq[2]));
   end

   // numerator vector and denominator
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            a_ff[k] <= A_W'(t1[k]) - A_W'(t2[k]);
         end
         den_ff <= nn_c << 1;
      end
   end

   // cross product with the normal
   for (genvar k = 0; k < 3; k++) begin : g_cross_mul
      localparam int K1 = (k + 1) % 3;
      localparam int K2 = (k + 2) % 3;
      tcc_mul #(.A_WIDTH(A_W), .B_WIDTH(NORM_W)) u_ca (
         .clock(clock), .en(en), .a(a_ff[K1]), .b(nd_ff[ML][K2]), .p(ca[k]));
      tcc_mul #(.A_WIDTH(A_W), .B_WIDTH(NORM_W)) u_cb (
         .clock(clock), .en(en), .a(a_ff[K2]), .b(nd_ff[ML][K1]), .p(cb[k]));
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cr_abs[k] = cr_ff[k][CR_W-1] ? CR_W'(-cr_ff[k]) : CR_W'(cr_ff[k]);
      end
   end

   // offset numerators, then magnitude, sign and range check
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            cr_ff[k]  <= CR_W'(ca[k]) - CR_W'(cb[k]);
            mag_ff[k] <= REM_W'(cr_abs[k]);
            neg_ff[k] <= cr_ff[k][CR_W-1];
            ovf_ff[k] <= REM_W'(cr_abs[k]) >= (REM_W'(dd_ff[ML]) << QUO_W);
         end
         den_h_ff <= dd_ff[ML];
      end
   end

   // restoring division, one quotient bit per stage
   always_comb begin
      for (int d = 0; d < QUO_W; d++) begin
         dsrc[d] = (d == 0) ? den_h_ff : dden_ff[(d == 0) ? 0 : d - 1];
         for (int k = 0; k < 3; k++) begin
            rsrc[d][k]  = (d == 0) ? mag_ff[k] : rem_ff[(d == 0) ? 0 : d - 1][k];
            qsrc[d][k]  = (d == 0) ? '0 : quo_ff[(d == 0) ? 0 : d - 1][k];
            trial[d][k] = {1'b0, rsrc[d][k]}
                        - {1'b0, (REM_W'(dsrc[d]) << (QUO_W - 1 - d))};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int d = 0; d < QUO_W; d++) begin
            dden_ff[d] <= dsrc[d];
            for (int k = 0; k < 3; k++) begin
               dneg_ff[d][k] <= (d == 0) ? neg_ff[k] : dneg_ff[(d == 0) ? 0 : d - 1][k];
               dovf_ff[d][k] <= (d == 0) ? ovf_ff[k] : dovf_ff[(d == 0) ? 0 : d - 1][k];
               if (!trial[d][k][REM_W]) begin
                  rem_ff[d][k] <= trial[d][k][REM_W-1:0];
                  quo_ff[d][k] <= qsrc[d][k] | (QUO_W'(1) << (QUO_W - 1 - d));
               end else begin
                  rem_ff[d][k] <= rsrc[d][k];
                  quo_ff[d][k] <= qsrc[d][k];
               end
            end
         end
      end
   end

   // rounding, vertex offset, saturation and degenerate select
   always_comb begin
      logic                    rnd;
      logic [QUO_W:0]          qm;
      logic signed [QUO_W+1:0] offs;
      logic signed [OUT_W-1:0] tot;
      logic [COORD_W-1:0]      res;
      logic                    sat_any;
      sat_any     = 1'b0;
      rsp_data_in = '0;
      for (int k = 0; k < 3; k++) begin
         rnd  = {rem_ff[QUO_W-1][k], 1'b0} >= (REM_W+1)'(dden_ff[QUO_W-1]);
         qm   = (QUO_W+1)'(quo_ff[QUO_W-1][k]) + (QUO_W+1)'(rnd);
         offs = dneg_ff[QUO_W-1][k] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
         tot  = OUT_W'(offs) + OUT_W'($signed(side_ff[TOT-1].p[k]));
         if (dovf_ff[QUO_W-1][k]) begin
            sat_any = 1'b1;
            res     = dneg_ff[QUO_W-1][k] ? SAT_MIN[COORD_W-1:0] : SAT_MAX[COORD_W-1:0];
         end else if (tot > SAT_MAX) begin
            sat_any = 1'b1;
            res     = SAT_MAX[COORD_W-1:0];
         end else if (tot < SAT_MIN) begin
            sat_any = 1'b1;
            res     = SAT_MIN[COORD_W-1:0];
         end else begin
            res = tot[COORD_W-1:0];
         end
         rsp_data_in[k*COORD_W +: COORD_W] = side_ff[TOT-1].pass ? res
                                                                 : side_ff[TOT-1].mid[k];
      end
      rsp_user_in                  = '0;
      rsp_user_in[USER_DEGENERATE] = !side_ff[TOT-1].pass;
      rsp_user_in[USER_SATURATED]  = side_ff[TOT-1].pass && sat_any;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= valid_ff[TOT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: design/tcc_mul.sv
// pipelined signed multiplier built from chunk partial products
module tcc_mul
   import tcc_pkg::*;
#(
   parameter int A_WIDTH = 32,
   parameter int B_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [A_WIDTH-1:0]         a,
   input  logic signed [B_WIDTH-1:0]         b,
   output logic signed [A_WIDTH+B_WIDTH-1:0] p
);

   localparam int NA    = (A_WIDTH + CHUNK_W - 1) / CHUNK_W;
   localparam int NB    = (B_WIDTH + CHUNK_W - 1) / CHUNK_W;
   localparam int PAD_A = NA * CHUNK_W;
   localparam int PAD_B = NB * CHUNK_W;
   localparam int P_W   = A_WIDTH + B_WIDTH;
   localparam int S_W   = (NA + NB) * CHUNK_W;

   logic [PAD_A-1:0]     am_ff;
   logic [PAD_B-1:0]     bm_ff;
   logic                 neg1_ff, neg2_ff, neg3_ff;
   logic [2*CHUNK_W-1:0] pp_ff [NA*NB];
   logic [P_W-1:0]       sum_ff;
   logic [P_W-1:0]       p_ff;
   logic [A_WIDTH-1:0]   a_abs;
   logic [B_WIDTH-1:0]   b_abs;
   logic [S_W-1:0]       acc;

   // magnitudes of the operands
   always_comb begin
      a_abs = a[A_WIDTH-1] ? A_WIDTH'(-a) : A_WIDTH'(a);
      b_abs = b[B_WIDTH-1] ? B_WIDTH'(-b) : B_WIDTH'(b);
   end

   // shifted sum of the partial products
   always_comb begin
      acc = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            acc = acc + (S_W'(pp_ff[i*NB+j]) << (CHUNK_W * (i + j)));
         end
      end
   end

   // four stages: magnitude, partials, sum, sign
   always_ff @(posedge clock) begin
      if (en) begin
         am_ff   <= PAD_A'(a_abs);
         bm_ff   <= PAD_B'(b_abs);
         neg1_ff <= a[A_WIDTH-1] ^ b[B_WIDTH-1];
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i*NB+j] <= am_ff[i*CHUNK_W +: CHUNK_W] * bm_ff[j*CHUNK_W +: CHUNK_W];
            end
         end
         neg2_ff <= neg1_ff;
         sum_ff  <= acc[P_W-1:0];
         neg3_ff <= neg2_ff;
         p_ff    <= neg3_ff ? -sum_ff : sum_ff;
      end
   end

   assign p = $signed(p_ff);

endmodule

// File: design/tcc_checker.sv
// port checker for the circumcenter unit and its bind
module tcc_checker
   import tcc_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [3*COORD_W-1:0] rsp_tdata,
   input logic [1:0]           rsp_tuser
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // degenerate results never report clipping
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[USER_DEGENERATE] && rsp_tuser[USER_SATURATED]))
      else $error("degenerate and saturated together");

   // reset empties the output register
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // input is taken exactly when the output side can move
   assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output stall");

endmodule

bind triangle_circumcenter_3d_unit tcc_checker u_tcc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
